// File: sv/ibl_pkg.sv
package ibl_pkg;

  // fixed scale factors and gains, Q16 / Q8.16
  localparam logic [23:0] ACC_K     = 24'd10283018;
  localparam logic [23:0] GYRO_K    = 24'd2287638;
  localparam logic [19:0] GRAVITY_Q = 20'd642690;
  localparam logic [15:0] DECAY_Q   = 16'd64881;
  localparam logic [13:0] FAST_LIMIT = 14'd1000;
  localparam logic [15:0] TH_001    = 16'd655;
  localparam logic [15:0] TH_005    = 16'd3277;
  localparam logic [15:0] TH_010    = 16'd6554;
  localparam logic [15:0] GAIN_03   = 16'd19661;
  localparam logic [15:0] GAIN_02   = 16'd13107;
  localparam logic [15:0] GAIN_05   = 16'd32768;
  localparam logic [15:0] GAIN_08   = 16'd52429;
  localparam logic [15:0] GAIN_095  = 16'd62259;

  // configuration register indexes
  localparam logic [2:0] CFG_GYRO_LIMIT = 3'd0;
  localparam logic [2:0] CFG_NORM_LOW   = 3'd1;
  localparam logic [2:0] CFG_NORM_HIGH  = 3'd2;
  localparam logic [2:0] CFG_ALPHA      = 3'd3;
  localparam logic [2:0] CFG_DEAD_BAND  = 3'd4;
  localparam logic [2:0] CFG_YAW_LIMIT  = 3'd5;
  localparam logic [2:0] CFG_COUNT_CAP  = 3'd6;

  typedef enum logic [3:0] {
    ST_IDLE, ST_MUL, ST_SCALE, ST_SQ, ST_SUM, ST_SROOT, ST_ZMUL,
    ST_ZSTART, ST_ZWAIT, ST_BSTART, ST_BWAIT, ST_YAW, ST_YAW2,
    ST_LMUL, ST_DONE
  } ibl_state_t;

  typedef struct packed {
    logic load;
    logic mul_scale;
    logic round_scale;
    logic mul_lpf;
    logic commit;
  } ibl_lane_ctl_t;

  // round to nearest, ties away from zero, divide by 65536
  function automatic logic signed [31:0] rnd16(input logic signed [47:0] p);
    logic [47:0] mag;
    logic [47:0] q;
    mag = p[47] ? 48'(-p) : 48'(p);
    q = (mag + 48'd32768) >> 16;
    return p[47] ? -$signed(q[31:0]) : $signed(q[31:0]);
  endfunction

  // saturate to 24 bits signed
  function automatic logic signed [23:0] sat24(input logic signed [31:0] v);
    if (v > 32'sd8388607) return 24'sh7fffff;
    else if (v < -32'sd8388608) return 24'sh800000;
    else return v[23:0];
  endfunction

endpackage

// File: sv/imu_bias_and_lowpass_conditioner.sv
// imu bias and low-pass conditioner
// input channel: one raw six-axis sample per request (in_valid / in_stall);
// in_stall is high whenever a sample is being worked on.
// result channel: six low-passed Q8.16 values and the stillness flag per
// request (out_valid / out_stall).
// configuration: cfg_we, cfg_index, cfg_data; write only while idle.
// each sample takes longer when still than when not still, from acceptance
// to result: every divider run holds the sequencer, once for the accel z
// correction and once per axis for the bias update, and the square root
// holds it as well.
// the next sample can be taken in the cycle after a result is loaded.
// six lanes scale and filter the axes side by side.
// a new sample is accepted while a result still waits; its filter update
// holds until that result is taken, so a stalled result never changes.
// reset: registers return to their defaults, biases, count and filter
// state clear, and the first sample after reset loads the filter directly.
module imu_bias_and_lowpass_conditioner import ibl_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] in_accel_x_raw,
  input  logic signed [15:0] in_accel_y_raw,
  input  logic signed [15:0] in_accel_z_raw,
  input  logic signed [15:0] in_rate_x_raw,
  input  logic signed [15:0] in_rate_y_raw,
  input  logic signed [15:0] in_rate_z_raw,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [23:0] out_accel_x_filtered,
  output logic signed [23:0] out_accel_y_filtered,
  output logic signed [23:0] out_accel_z_filtered,
  output logic signed [23:0] out_rate_x_filtered,
  output logic signed [23:0] out_rate_y_filtered,
  output logic signed [23:0] out_rate_z_filtered,
  output logic               out_still_flag,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [22:0]        cfg_data
);

  ibl_state_t state_r, state_nxt;
  ibl_lane_ctl_t lane_ctl;

  logic [19:0] gyro_limit_r;
  logic [22:0] norm_low_r, norm_high_r;
  logic [15:0] alpha_r, dead_band_r, yaw_limit_r;
  logic [13:0] count_cap_r, count_r;

  logic signed [23:0] bias_r [3];
  logic signed [47:0] sq_r [3];
  logic signed [47:0] zprod_r, ymul_r;
  logic signed [23:0] accz_r;
  logic signed [25:0] vz_r;
  logic [1:0]  ax_r;
  logic        still_r, yaw_alone_r, yzero_r, decay_r, first_r;
  logic        out_valid_r, out_still_r;

  logic signed [15:0] raw [6];
  logic [23:0]        lane_k [6];
  logic signed [25:0] lane_v [6];
  logic signed [23:0] scaled [6];
  logic signed [23:0] filt [6];

  logic        sqrt_start, sqrt_done, div_start, div_done;
  logic [23:0] norm, div_den;
  logic signed [47:0] div_num;
  logic signed [31:0] div_quo;
  logic [47:0] rad;

  logic [23:0] abs_r0, abs_r1, abs_r2;
  logic [25:0] l1;
  logic        still_now;
  logic [13:0] cap_eff;
  logic [14:0] count_inc;
  logic signed [23:0] rate_sel, bias_sel;
  logic signed [25:0] y;
  logic [25:0] ay;
  logic [15:0] yaw_gain;
  logic signed [47:0] y_x, bias2_x;
  logic signed [31:0] ymul_rnd;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gyro_limit_r <= 20'd6554;
      norm_low_r   <= 23'd578420;
      norm_high_r  <= 23'd706958;
      alpha_r      <= 16'd11796;
      dead_band_r  <= 16'd131;
      yaw_limit_r  <= 16'd1311;
      count_cap_r  <= 14'd10000;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_GYRO_LIMIT: gyro_limit_r <= cfg_data[19:0];
        CFG_NORM_LOW:   norm_low_r   <= cfg_data;
        CFG_NORM_HIGH:  norm_high_r  <= cfg_data;
        CFG_ALPHA:      alpha_r      <= cfg_data[15:0];
        CFG_DEAD_BAND:  dead_band_r  <= cfg_data[15:0];
        CFG_YAW_LIMIT:  yaw_limit_r  <= cfg_data[15:0];
        CFG_COUNT_CAP:  count_cap_r  <= cfg_data[13:0];
        default: ;
      endcase
    end
  end

  // six axis lanes
  assign raw[0] = in_accel_x_raw;
  assign raw[1] = in_accel_y_raw;
  assign raw[2] = in_accel_z_raw;
  assign raw[3] = in_rate_x_raw;
  assign raw[4] = in_rate_y_raw;
  assign raw[5] = in_rate_z_raw;

  assign lane_v[0] = 26'(scaled[0]);
  assign lane_v[1] = 26'(scaled[1]);
  assign lane_v[2] = 26'(accz_r);
  assign lane_v[3] = 26'(scaled[3]) - 26'(bias_r[0]);
  assign lane_v[4] = 26'(scaled[4]) - 26'(bias_r[1]);
  assign lane_v[5] = vz_r;

  for (genvar i = 0; i < 6; i++) begin : g_lane
    assign lane_k[i] = (i < 3) ? ACC_K : GYRO_K;
    ibl_lane u_lane (
      .clk    (clk),
      .rst_n  (rst_n),
      .ctl    (lane_ctl),
      .raw_in (raw[i]),
      .k      (lane_k[i]),
      .v      (lane_v[i]),
      .alpha  (alpha_r),
      .first  (first_r),
      .scaled (scaled[i]),
      .filt   (filt[i])
    );
  end

  // shared square root and divider
  assign rad = 48'(sq_r[0]) + 48'(sq_r[1]) + 48'(sq_r[2]);

  ibl_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sqrt_start),
    .rad   (rad),
    .done  (sqrt_done),
    .root  (norm)
  );

  always_comb begin
    case (ax_r)
      2'd0:    begin rate_sel = scaled[3]; bias_sel = bias_r[0]; end
      2'd1:    begin rate_sel = scaled[4]; bias_sel = bias_r[1]; end
      default: begin rate_sel = scaled[5]; bias_sel = bias_r[2]; end
    endcase
  end

  assign div_num = (state_r == ST_ZSTART) ? zprod_r : 48'(rate_sel) - 48'(bias_sel);
  assign div_den = (state_r == ST_ZSTART) ? norm : 24'(count_r);

  ibl_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  // stillness test
  assign abs_r0 = scaled[3][23] ? 24'(-scaled[3]) : 24'(scaled[3]);
  assign abs_r1 = scaled[4][23] ? 24'(-scaled[4]) : 24'(scaled[4]);
  assign abs_r2 = scaled[5][23] ? 24'(-scaled[5]) : 24'(scaled[5]);
  assign l1 = 26'(abs_r0) + 26'(abs_r1) + 26'(abs_r2);
  assign still_now = (l1 < 26'(gyro_limit_r)) && (norm > 24'(norm_low_r))
                     && (norm < 24'(norm_high_r));
  assign cap_eff = (count_cap_r == '0) ? 14'd1 : count_cap_r;
  assign count_inc = 15'(count_r) + 15'd1;

  // yaw path
  assign y  = 26'(scaled[5]) - 26'(bias_r[2]);
  assign ay = y[25] ? 26'(-y) : 26'(y);
  assign y_x = 48'(y);
  assign bias2_x = 48'(bias_r[2]);
  assign ymul_rnd = rnd16(ymul_r);

  always_comb begin
    if (ay < 26'(TH_001))      yaw_gain = GAIN_02;
    else if (ay < 26'(TH_005)) yaw_gain = GAIN_05;
    else if (ay < 26'(TH_010)) yaw_gain = GAIN_08;
    else                       yaw_gain = GAIN_095;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (in_valid) state_nxt = ST_MUL;
      ST_MUL:    state_nxt = ST_SCALE;
      ST_SCALE:  state_nxt = ST_SQ;
      ST_SQ:     state_nxt = ST_SUM;
      ST_SUM:    state_nxt = ST_SROOT;
      ST_SROOT:  if (sqrt_done) state_nxt = ST_ZMUL;
      ST_ZMUL:   state_nxt = ST_ZSTART;
      ST_ZSTART: state_nxt = ST_ZWAIT;
      ST_ZWAIT:  if (div_done) state_nxt = still_r ? ST_BSTART : ST_YAW;
      ST_BSTART: state_nxt = ST_BWAIT;
      ST_BWAIT:  if (div_done) state_nxt = (ax_r == 2'd2) ? ST_YAW : ST_BSTART;
      ST_YAW:    state_nxt = ST_YAW2;
      ST_YAW2:   state_nxt = ST_LMUL;
      ST_LMUL:   state_nxt = ST_DONE;
      ST_DONE:   if (!out_valid_r || !out_stall) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    lane_ctl.load        = (state_r == ST_IDLE) && in_valid;
    lane_ctl.mul_scale   = (state_r == ST_MUL);
    lane_ctl.round_scale = (state_r == ST_SCALE);
    lane_ctl.mul_lpf     = (state_r == ST_LMUL);
    lane_ctl.commit      = (state_r == ST_DONE) && (!out_valid_r || !out_stall);
    sqrt_start           = (state_r == ST_SUM);
    div_start            = (state_r == ST_ZSTART) || (state_r == ST_BSTART);
    in_stall             = (state_r != ST_IDLE);
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      first_r     <= 1'b1;
      out_valid_r <= 1'b0;
      count_r     <= '0;
      ax_r        <= '0;
      bias_r[0]   <= '0;
      bias_r[1]   <= '0;
      bias_r[2]   <= '0;
    end else begin
      state_r <= state_nxt;
      if (lane_ctl.commit) begin
        first_r     <= 1'b0;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (state_r == ST_ZMUL) begin
        ax_r <= '0;
        if (still_now) count_r <= (count_inc > 15'(cap_eff)) ? cap_eff : count_inc[13:0];
      end
      if (state_r == ST_BWAIT && div_done) begin
        bias_r[ax_r] <= sat24(32'(bias_sel) + div_quo);
        ax_r <= ax_r + 2'd1;
      end
      if (state_r == ST_YAW2 && decay_r) bias_r[2] <= ymul_rnd[23:0];
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (state_r == ST_SQ) begin
      sq_r[0] <= 48'(scaled[0]) * 48'(scaled[0]);
      sq_r[1] <= 48'(scaled[1]) * 48'(scaled[1]);
      sq_r[2] <= 48'(scaled[2]) * 48'(scaled[2]);
    end
    if (state_r == ST_ZMUL) begin
      zprod_r     <= 48'(scaled[2]) * $signed(48'(GRAVITY_Q));
      still_r     <= still_now;
      yaw_alone_r <= abs_r2 < 24'(yaw_limit_r);
    end
    if (state_r == ST_ZWAIT && div_done) accz_r <= (norm == '0) ? '0 : div_quo[23:0];
    if (state_r == ST_YAW) begin
      yzero_r <= 1'b0;
      decay_r <= 1'b0;
      if (ay < 26'(dead_band_r)) begin
        yzero_r <= 1'b1;
        ymul_r  <= '0;
      end else if (still_r) begin
        yzero_r <= 1'b1;
        decay_r <= count_r < FAST_LIMIT;
        ymul_r  <= bias2_x * $signed(48'(DECAY_Q));
      end else if (yaw_alone_r) begin
        ymul_r  <= y_x * $signed(48'(GAIN_03));
      end else begin
        ymul_r  <= y_x * $signed(48'(yaw_gain));
      end
    end
    if (state_r == ST_YAW2) vz_r <= yzero_r ? '0 : ymul_rnd[25:0];
    if (lane_ctl.commit) out_still_r <= still_r;
  end

  assign out_valid            = out_valid_r;
  assign out_still_flag       = out_still_r;
  assign out_accel_x_filtered = filt[0];
  assign out_accel_y_filtered = filt[1];
  assign out_accel_z_filtered = filt[2];
  assign out_rate_x_filtered  = filt[3];
  assign out_rate_y_filtered  = filt[4];
  assign out_rate_z_filtered  = filt[5];

endmodule

// File: sv/ibl_div.sv
module ibl_div import ibl_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [47:0] num,
  input  logic [23:0]        den,
  output logic               done,
  output logic signed [31:0] quo
);

  localparam int NW = 49;
  localparam int DW = 24;
  localparam int CW = $clog2(NW);

  logic [NW-1:0] q_r;
  logic [DW-1:0] rem_r, den_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r, done_r, neg_r;
  logic [NW-1:0] mag;
  logic [DW:0]   rem_sh;
  logic          ge;

  // rounding bias added to the magnitude before the divide
  assign mag = (num[47] ? NW'(-num) : NW'(num)) + NW'(den >> 1);
  assign rem_sh = {rem_r, q_r[NW-1]};
  assign ge = rem_sh >= {1'b0, den_r};

  // restoring division, one quotient bit a cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        q_r    <= mag;
        rem_r  <= '0;
        den_r  <= den;
        neg_r  <= num[47];
      end else if (busy_r) begin
        rem_r <= ge ? DW'(rem_sh - {1'b0, den_r}) : DW'(rem_sh);
        q_r   <= {q_r[NW-2:0], ge};
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(NW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quo  = neg_r ? -$signed(q_r[31:0]) : $signed(q_r[31:0]);

endmodule

// File: sv/ibl_sqrt.sv
module ibl_sqrt import ibl_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [47:0] rad,
  output logic        done,
  output logic [23:0] root
);

  logic [47:0] x_r, r_r, bit_r, t;
  logic        busy_r, done_r;

  assign t = r_r + bit_r;

  // digit-by-digit square root, one result bit a cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        x_r    <= rad;
        r_r    <= '0;
        bit_r  <= 48'h1 << 46;
      end else if (busy_r) begin
        if (x_r >= t) begin
          x_r <= x_r - t;
          r_r <= (r_r >> 1) + bit_r;
        end else begin
          r_r <= r_r >> 1;
        end
        bit_r <= bit_r >> 2;
        if (bit_r == 48'h1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign root = r_r[23:0];

endmodule

// File: sv/ibl_lane.sv
module ibl_lane import ibl_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  ibl_lane_ctl_t      ctl,
  input  logic signed [15:0] raw_in,
  input  logic [23:0]        k,
  input  logic signed [25:0] v,
  input  logic [15:0]        alpha,
  input  logic               first,
  output logic signed [23:0] scaled,
  output logic signed [23:0] filt
);

  logic signed [15:0] raw_r;
  logic signed [47:0] prod_r;
  logic signed [23:0] scaled_r, f_r;
  logic signed [47:0] raw_x, k_x, diff_x, alpha_x;
  logic signed [31:0] prod_rnd;
  logic signed [31:0] f_sum;

  assign raw_x    = 48'(raw_r);
  assign k_x      = $signed(48'(k));
  assign diff_x   = 48'(v) - 48'(f_r);
  assign alpha_x  = $signed(48'(alpha));
  assign prod_rnd = rnd16(prod_r);
  assign f_sum    = 32'(f_r) + prod_rnd;

  // sample capture and shared product register
  always_ff @(posedge clk) begin
    if (ctl.load) raw_r <= raw_in;
    if (ctl.mul_scale) prod_r <= raw_x * k_x;
    else if (ctl.mul_lpf) prod_r <= alpha_x * diff_x;
    if (ctl.round_scale) scaled_r <= prod_rnd[23:0];
  end

  // low-pass state, first sample loaded directly
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_r <= '0;
    end else if (ctl.commit) begin
      f_r <= first ? sat24(32'(v)) : sat24(f_sum);
    end
  end

  assign scaled = scaled_r;
  assign filt   = f_r;

endmodule
